### hw/rtl/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg: shared types and constants of the sorted list
// Request codes, field widths, controller states and the per-cell command.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned DATA_W    = 8;
  localparam int unsigned OUT_CNT_W = 4;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_type_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_HOLD
  } state_e;

  typedef logic signed [DATA_W-1:0] data_t;

  // Command broadcast to every cell
  typedef struct packed {
    logic  ins_en;
    logic  rem_en;
    data_t value;
  } cell_cmd_t;

endpackage

### hw/rtl/sli_if.sv
// ----------------------------------------------------------------------------
// sli_req_if / sli_rsp_if: request and response channels
// Valid/ready handshake; an item moves when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface sli_req_if;
  logic                 valid;
  logic                 ready;
  logic                 req_type;
  logic signed [7:0]    value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface sli_rsp_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           entry_count;
  logic signed [7:0]    smallest;
  logic signed [7:0]    largest;
  logic [3:0]           removed_count;
  logic                 dropped;

  modport source (output valid, output entry_count, output smallest, output largest,
                  output removed_count, output dropped, input ready);
  modport sink   (input valid, input entry_count, input smallest, input largest,
                  input removed_count, input dropped, output ready);
endinterface

### hw/rtl/sli_cell.sv
// ----------------------------------------------------------------------------
// sli_cell: one entry of the sorted list
// Takes its left neighbour's or the new value on insert, its right neighbour's
// on a compaction step; passes compare and shift flags along the chain.
// ----------------------------------------------------------------------------
module sli_cell #(
  parameter int unsigned CntW  = 4,
  parameter int unsigned Index = 0
) (
  input  logic                clk_i,
  input  sli_pkg::cell_cmd_t  cmd_i,
  input  logic [CntW-1:0]     count_i,
  input  sli_pkg::data_t      left_data_i,
  input  logic                left_gt_i,
  input  sli_pkg::data_t      right_data_i,
  input  logic                shift_i,
  output sli_pkg::data_t      data_o,
  output logic                gt_o,
  output logic                shift_o
);
  import sli_pkg::*;

  localparam logic [CntW-1:0] IDX = CntW'(Index);

  data_t data_q, data_d;
  logic  valid;
  logic  take_new;

  assign valid   = IDX < count_i;
  assign gt_o    = valid && (data_q > cmd_i.value);
  assign shift_o = valid && ((data_q == cmd_i.value) || shift_i);
  assign take_new = gt_o || (IDX == count_i);

  always_comb begin
    data_d = data_q;
    if (cmd_i.ins_en && take_new) begin
      data_d = left_gt_i ? left_data_i : cmd_i.value;
    end else if (cmd_i.rem_en && shift_o) begin
      data_d = right_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/sorted_list_insert_remove_top.sv
// Insert updates the cells when the request is accepted; remove deletes one
// matching entry per compaction step, one step per cycle, until none is left.
// One item at a time; the next is taken once the result is loaded.
// The compaction chain across the cells sets the remove time.
// Reset clears the entry count and control; cell contents are not reset.
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top: sorted list with insert and remove-all
// Chain of cells holding the entries in ascending order, plus controller.
// ----------------------------------------------------------------------------
module sorted_list_insert_remove_top #(
  parameter int unsigned CAPACITY = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sli_req_if.sink    req_i,
  sli_rsp_if.source  rsp_o
);
  import sli_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  removed_q, removed_d;
  logic              drop_q, drop_d;
  data_t             value_q, value_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_CNT_W-1:0] out_count_q, out_removed_q;
  data_t             out_small_q, out_large_q;
  logic              out_drop_q;

  cell_cmd_t         cmd;
  data_t             cell_data [CAPACITY];
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_shift;
  logic              req_fire;
  logic              any_match;
  logic              load_out;
  logic [IDX_W-1:0]  last_idx;

  assign req_fire  = req_i.valid && req_i.ready;
  assign any_match = |cell_shift;
  assign last_idx  = IDX_W'(count_q - CNT_W'(1));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    data_t left_d, right_d;
    logic  left_gt, shift_in;
    if (i == 0) begin : g_first
      assign left_d   = '0;
      assign left_gt  = 1'b0;
      assign shift_in = 1'b0;
    end else begin : g_mid
      assign left_d   = cell_data[i-1];
      assign left_gt  = cell_gt[i-1];
      assign shift_in = cell_shift[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cell_data[i+1];
    end
    sli_cell #(
      .CntW  (CNT_W),
      .Index (i)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd),
      .count_i      (count_q),
      .left_data_i  (left_d),
      .left_gt_i    (left_gt),
      .right_data_i (right_d),
      .shift_i      (shift_in),
      .data_o       (cell_data[i]),
      .gt_o         (cell_gt[i]),
      .shift_o      (cell_shift[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = (req_i.req_type == REQ_REMOVE) ? ST_REMOVE : ST_HOLD;
        end
      end
      ST_REMOVE: begin
        if (!any_match) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control
  always_comb begin
    req_i.ready  = 1'b0;
    cmd.ins_en   = 1'b0;
    cmd.rem_en   = 1'b0;
    cmd.value    = value_q;
    load_out     = 1'b0;
    count_d      = count_q;
    removed_d    = removed_q;
    drop_d       = drop_q;
    value_d      = value_q;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        cmd.value   = req_i.value;
        if (req_fire) begin
          value_d   = req_i.value;
          removed_d = '0;
          drop_d    = 1'b0;
          if (req_i.req_type == REQ_INSERT) begin
            if (count_q < CAP) begin
              cmd.ins_en = 1'b1;
              count_d    = count_q + CNT_W'(1);
            end else begin
              drop_d = 1'b1;
            end
          end
        end
      end
      ST_REMOVE: begin
        if (any_match) begin
          cmd.rem_en = 1'b1;
          count_d    = count_q - CNT_W'(1);
          removed_d  = removed_q + CNT_W'(1);
        end
      end
      ST_HOLD: begin
        load_out = !out_valid_q || rsp_o.ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    removed_q <= removed_d;
    drop_q    <= drop_d;
    value_q   <= value_d;
    if (load_out) begin
      out_count_q   <= OUT_CNT_W'(count_q);
      out_removed_q <= OUT_CNT_W'(removed_q);
      out_drop_q    <= drop_q;
      out_small_q   <= (count_q == '0) ? data_t'(0) : cell_data[0];
      out_large_q   <= (count_q == '0) ? data_t'(0) : cell_data[last_idx];
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.entry_count   = out_count_q;
  assign rsp_o.smallest      = out_small_q;
  assign rsp_o.largest       = out_large_q;
  assign rsp_o.removed_count = out_removed_q;
  assign rsp_o.dropped       = out_drop_q;

endmodule
